[rtl/core/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the RTL in this folder
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a condition at one edge implies another at the next edge
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/mfsgd_pkg.sv]
// ---------------------------------------------------------------------------
// mfsgd_pkg
// Types, codes and helpers of the latent-factor SGD update block.
// ---------------------------------------------------------------------------
package mfsgd_pkg;

  // Operation codes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_RATE  = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_LR    = 2'd0;
  localparam logic [1:0] REG_DECAY = 2'd1;
  localparam logic [1:0] REG_LAMBDA = 2'd2;

  // Reset values of the configuration registers
  localparam logic [31:0] LR_RESET     = 32'd655;
  localparam logic [31:0] DECAY_RESET  = 32'd6554;
  localparam logic [31:0] LAMBDA_RESET = 32'd65536;

  typedef struct packed {
    logic [1:0]         op;
    logic               side;
    logic [9:0]         item_index;
    logic [11:0]        user_index;
    logic [3:0]         element_index;
    logic signed [31:0] write_value;
    logic [7:0]         rating;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic signed [31:0] prediction_error;
  } res_t;

  // Clamp a wide signed value to signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    logic signed [31:0] r;
    if (v > 50'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -50'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

[rtl/core/mfsgd_ram.sv]
// ---------------------------------------------------------------------------
// mfsgd_ram
// Single-port RAM with registered read, read-before-write.
// ---------------------------------------------------------------------------
module mfsgd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read one address per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[rtl/core/mf_sgd_latent_update.sv]
// ---------------------------------------------------------------------------
// mf_sgd_latent_update
// Latent-factor SGD update engine for matrix factorization.
// ---------------------------------------------------------------------------
// One command at a time; busy stays high until its result beat. The dot
// product and the vector update walk the elements through one shared 33x33
// multiplier, the square root of the item's update count plus one is found
// one bit per cycle and so is the step divide. Every command, also a no-op or
// one with an index out of range, returns exactly one result beat, marked by
// done for one cycle; the receiver must take it then. After reset the update
// counters are cleared, one per cycle, while busy stays high. Configuration
// writes are always taken.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mf_sgd_latent_update
  import mfsgd_pkg::*;
#(
  parameter int LATENT_SIZE = 16,
  parameter int NUM_ITEMS   = 1024,
  parameter int NUM_USERS   = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  cmd_t        cmd,
  output logic        done,
  output res_t        result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int IW = (NUM_ITEMS * LATENT_SIZE > 1) ? $clog2(NUM_ITEMS * LATENT_SIZE) : 1;
  localparam int UW = (NUM_USERS * LATENT_SIZE > 1) ? $clog2(NUM_USERS * LATENT_SIZE) : 1;
  localparam int CW = (NUM_ITEMS > 1) ? $clog2(NUM_ITEMS) : 1;
  localparam int KW = (LATENT_SIZE > 1) ? $clog2(LATENT_SIZE) : 1;

  typedef enum logic [23:0] {
    S_CLEAR   = 24'd1 << 0,
    S_IDLE    = 24'd1 << 1,
    S_ACCESS  = 24'd1 << 2,
    S_RWAIT   = 24'd1 << 3,
    S_DOT_RD  = 24'd1 << 4,
    S_DOT_MUL = 24'd1 << 5,
    S_DOT_ACC = 24'd1 << 6,
    S_ERR     = 24'd1 << 7,
    S_SQRT    = 24'd1 << 8,
    S_PMUL    = 24'd1 << 9,
    S_PH      = 24'd1 << 10,
    S_PL      = 24'd1 << 11,
    S_DEN     = 24'd1 << 12,
    S_DIV     = 24'd1 << 13,
    S_STEP    = 24'd1 << 14,
    S_UPD_RD  = 24'd1 << 15,
    S_UM1     = 24'd1 << 16,
    S_UM2     = 24'd1 << 17,
    S_UM3     = 24'd1 << 18,
    S_UM4     = 24'd1 << 19,
    S_UM5     = 24'd1 << 20,
    S_UM6     = 24'd1 << 21,
    S_UM7     = 24'd1 << 22,
    S_UM8     = 24'd1 << 23
  } state_t;

  state_t state;

  // Configuration registers
  logic [31:0] lr, decay, lam;

  // Captured command and addressing
  cmd_t          c;
  logic          ok_rw, ok_rate;
  logic [IW-1:0] base_i;
  logic [UW-1:0] base_u;
  logic [KW-1:0] k;
  logic [CW-1:0] clr_addr;
  logic [5:0]    itc;

  // Datapath registers
  logic signed [65:0] prod;
  logic signed [49:0] acc, t;
  logic signed [31:0] g, mo, uo, err_q, rd_val;
  logic [49:0]        xs;
  logic [26:0]        rem_s;
  logic [24:0]        root;
  logic [15:0]        pl;
  logic [58:0]        den, rem_d;
  logic [62:0]        num, q;
  logic [31:0]        step;

  // Memory ports
  logic          i_we, u_we, c_we;
  logic [IW-1:0] i_addr;
  logic [UW-1:0] u_addr;
  logic [CW-1:0] c_addr;
  logic [31:0]   i_wdata, u_wdata, i_rdata, u_rdata;
  logic [15:0]   c_wdata, c_rdata;

  // Shared multiplier operands and shifted products
  logic signed [32:0] mul_a, mul_b;
  logic signed [49:0] p24, p16, p30;
  logic [16:0]        n1;
  logic [28:0]        rem_sh, trial;
  logic [59:0]        rs;
  logic               k_last;

  assign p24    = 50'(prod >>> 24);
  assign p16    = 50'(prod >>> 16);
  assign p30    = 50'(prod >>> 30);
  assign n1     = 17'(c_rdata) + 17'd1;
  assign rem_sh = {rem_s, xs[49:48]};
  assign trial  = {2'b00, root, 2'b01};
  assign rs     = {rem_d, num[62]};
  assign k_last = (k == KW'(LATENT_SIZE - 1));

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign result.read_value       = rd_val;
  assign result.prediction_error = err_q;

  // Select multiplier operands per step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_DOT_MUL: begin
        mul_a = 33'(signed'(u_rdata));
        mul_b = 33'(signed'(i_rdata));
      end
      S_PMUL: begin
        mul_a = 33'(n1);
        mul_b = 33'(root);
      end
      S_PH: begin
        mul_a = {1'b0, decay};
        mul_b = 33'(prod[41:16]);
      end
      S_PL: begin
        mul_a = {1'b0, decay};
        mul_b = 33'(pl);
      end
      S_UM1: begin
        mul_a = 33'(err_q);
        mul_b = 33'(signed'(u_rdata));
      end
      S_UM2: begin
        mul_a = {1'b0, lam};
        mul_b = 33'(mo);
      end
      S_UM3: begin
        mul_a = 33'(err_q);
        mul_b = 33'(mo);
      end
      S_UM4, S_UM7: begin
        mul_a = {1'b0, step};
        mul_b = 33'(g);
      end
      S_UM5: begin
        mul_a = {1'b0, lam};
        mul_b = 33'(uo);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Drive memory ports
  always_comb begin
    i_addr  = base_i + IW'(k);
    u_addr  = base_u + UW'(k);
    c_addr  = (state == S_CLEAR) ? clr_addr : CW'(c.item_index);
    i_we    = 1'b0;
    u_we    = 1'b0;
    c_we    = 1'b0;
    i_wdata = c.write_value;
    u_wdata = c.write_value;
    c_wdata = (c_rdata == 16'hFFFF) ? c_rdata : c_rdata + 16'd1;
    case (state)
      S_CLEAR: begin
        c_we    = 1'b1;
        c_wdata = '0;
      end
      S_ACCESS: begin
        i_we = (c.op == OP_WRITE) && ok_rw && !c.side;
        u_we = (c.op == OP_WRITE) && ok_rw && c.side;
      end
      S_UM5: begin
        i_we    = 1'b1;
        i_wdata = sat32(50'(mo) - p30);
      end
      S_UM8: begin
        u_we    = 1'b1;
        u_wdata = sat32(50'(uo) - p30);
      end
      default: begin
        i_we = 1'b0;
      end
    endcase
    if (state == S_UM8 && k_last) begin
      c_we = 1'b1;
    end
  end

  mfsgd_ram #(.WIDTH(32), .DEPTH(NUM_ITEMS * LATENT_SIZE)) u_item_ram (
    .clk(clk), .we(i_we), .addr(i_addr), .wdata(i_wdata), .rdata(i_rdata)
  );

  mfsgd_ram #(.WIDTH(32), .DEPTH(NUM_USERS * LATENT_SIZE)) u_user_ram (
    .clk(clk), .we(u_we), .addr(u_addr), .wdata(u_wdata), .rdata(u_rdata)
  );

  mfsgd_ram #(.WIDTH(16), .DEPTH(NUM_ITEMS)) u_count_ram (
    .clk(clk), .we(c_we), .addr(c_addr), .wdata(c_wdata), .rdata(c_rdata)
  );

  // Register every product
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      lr    <= LR_RESET;
      decay <= DECAY_RESET;
      lam   <= LAMBDA_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LR:     lr    <= cfg_data;
        REG_DECAY:  decay <= cfg_data;
        REG_LAMBDA: lam   <= cfg_data;
        default:    lr    <= lr;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + CW'(1);
          if (clr_addr == CW'(NUM_ITEMS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            state <= S_ACCESS;
          end
        end
        S_ACCESS: begin
          if (c.op == OP_READ && ok_rw) begin
            state <= S_RWAIT;
          end else if (c.op == OP_RATE && ok_rate) begin
            state <= S_DOT_RD;
          end else begin
            state <= S_IDLE;
            done  <= 1'b1;
          end
        end
        S_RWAIT: begin
          state <= S_IDLE;
          done  <= 1'b1;
        end
        S_DOT_RD:  state <= S_DOT_MUL;
        S_DOT_MUL: state <= S_DOT_ACC;
        S_DOT_ACC: state <= k_last ? S_ERR : S_DOT_RD;
        S_ERR:     state <= S_SQRT;
        S_SQRT: begin
          if (itc == 6'd0) begin
            state <= S_PMUL;
          end
        end
        S_PMUL: state <= S_PH;
        S_PH:   state <= S_PL;
        S_PL:   state <= S_DEN;
        S_DEN:  state <= S_DIV;
        S_DIV: begin
          if (itc == 6'd0) begin
            state <= S_STEP;
          end
        end
        S_STEP:   state <= S_UPD_RD;
        S_UPD_RD: state <= S_UM1;
        S_UM1:    state <= S_UM2;
        S_UM2:    state <= S_UM3;
        S_UM3:    state <= S_UM4;
        S_UM4:    state <= S_UM5;
        S_UM5:    state <= S_UM6;
        S_UM6:    state <= S_UM7;
        S_UM7:    state <= S_UM8;
        S_UM8: begin
          if (k_last) begin
            state <= S_IDLE;
            done  <= 1'b1;
          end else begin
            state <= S_UPD_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        c       <= cmd;
        ok_rw   <= (cmd.side ? (32'(cmd.user_index) < 32'(NUM_USERS))
                             : (32'(cmd.item_index) < 32'(NUM_ITEMS)))
                   && (32'(cmd.element_index) < 32'(LATENT_SIZE));
        ok_rate <= (32'(cmd.item_index) < 32'(NUM_ITEMS))
                   && (32'(cmd.user_index) < 32'(NUM_USERS));
        base_i  <= IW'(32'(cmd.item_index) * 32'(LATENT_SIZE));
        base_u  <= UW'(32'(cmd.user_index) * 32'(LATENT_SIZE));
        k       <= (cmd.op == OP_RATE) ? '0 : KW'(cmd.element_index);
        rd_val  <= '0;
        err_q   <= '0;
        acc     <= '0;
      end
      S_ACCESS: begin
        if (c.op == OP_RATE) begin
          k <= '0;
        end
      end
      S_RWAIT: begin
        rd_val <= c.side ? signed'(u_rdata) : signed'(i_rdata);
      end
      S_DOT_ACC: begin
        acc <= acc + p24;
        if (!k_last) begin
          k <= k + KW'(1);
        end
      end
      S_ERR: begin
        err_q <= sat32(acc - signed'({18'b0, c.rating, 24'b0}));
        xs    <= {1'b0, n1, 32'b0};
        rem_s <= '0;
        root  <= '0;
        itc   <= 6'd24;
      end
      S_SQRT: begin
        // One root bit per cycle
        if (rem_sh >= trial) begin
          rem_s <= 27'(rem_sh - trial);
          root  <= {root[23:0], 1'b1};
        end else begin
          rem_s <= 27'(rem_sh);
          root  <= {root[23:0], 1'b0};
        end
        xs  <= {xs[47:0], 2'b00};
        itc <= itc - 6'd1;
      end
      S_PH: begin
        pl <= prod[15:0];
      end
      S_PL: begin
        den <= 59'd65536 + 59'(prod[57:0]);
      end
      S_DEN: begin
        den   <= den + 59'(prod[47:16]);
        num   <= {({2'b00, lr} + {1'b0, lr, 1'b0}), 29'b0};
        rem_d <= '0;
        q     <= '0;
        itc   <= 6'd62;
      end
      S_DIV: begin
        // One quotient bit per cycle
        if (rs >= {1'b0, den}) begin
          rem_d <= 59'(rs - {1'b0, den});
          q     <= {q[61:0], 1'b1};
        end else begin
          rem_d <= rs[58:0];
          q     <= {q[61:0], 1'b0};
        end
        num <= {num[61:0], 1'b0};
        itc <= itc - 6'd1;
      end
      S_STEP: begin
        step <= (q[62:32] != '0) ? 32'hFFFFFFFF : q[31:0];
        k    <= '0;
      end
      S_UM1: begin
        mo <= signed'(i_rdata);
        uo <= signed'(u_rdata);
      end
      S_UM2, S_UM4: t <= p24;
      S_UM3, S_UM6: g <= sat32(t + p16);
      S_UM8: begin
        if (!k_last) begin
          k <= k + KW'(1);
        end
      end
      default: begin
        t <= t;
      end
    endcase
  end

  `ASSERT_NEXT(a_done_pulse, done, !done, "result strobe longer than one cycle")
  `ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted command did not raise busy")
  `ASSERT_ALWAYS(a_done_idle, !done || !busy, "result strobe while busy")

endmodule
